FILE: hdl/lis_pkg.sv
// Shared constants and types for the increasing-subsequence length tracker.
package lis_pkg;

    // Default table depth and value width.
    localparam int unsigned TABLE_DEPTH_DEF = 64;
    localparam int unsigned VALUE_WIDTH_DEF = 32;

    // Width of the reported length field.
    localparam int unsigned LEN_W = 7;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic en;      // advance the chain this cycle
        logic append;  // the token sits at the first free cell
    } t_cell_ctl;

endpackage

FILE: hdl/lis_cell.sv
// One cell of the tail chain: holds one tail value and passes the search token on.
module lis_cell
    import lis_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctl              i_ctl,
    input  logic                   i_tok,
    input  logic [VALUE_WIDTH-1:0] i_key,
    output logic                   o_tok,
    output logic [VALUE_WIDTH-1:0] o_key,
    output logic                   o_hit
);

    logic                   r_tok;
    logic [VALUE_WIDTH-1:0] r_key;
    logic [VALUE_WIDTH-1:0] r_value;

    // The token stops here at the first free cell or at the ceiling entry.
    assign o_hit = r_tok & (i_ctl.append | ($signed(r_key) <= $signed(r_value)));
    assign o_tok = r_tok & ~o_hit;
    assign o_key = r_key;

    // Token position moves one cell per enabled cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else if (i_ctl.en) begin
            r_tok <= i_tok;
        end
    end

    // Search key travels with the token.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en && i_tok) begin
            r_key <= i_key;
        end
    end

    // A hit overwrites the stored tail with the key.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en && o_hit) begin
            r_value <= r_key;
        end
    end

endmodule

FILE: hdl/lis_length_tracker_top.sv
// Top level: sequencer, output register and the chain of tail cells.
// A word is held, launched into the chain and walks to the cell where it stops (its ceiling,
// or the first free cell on an append), then lands in the output register; an overflow walks
// past the last cell. One word is in work at a time: the next is accepted once the result is
// registered. The token walks one cell per cycle unless an output stall holds the chain.
// Reset (synchronous, active low) clears the length and control; tail values are not cleared.
module lis_length_tracker_top
    import lis_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_sample,
    input  logic                          i_start_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [LEN_W-1:0]              o_lis_length,
    output logic                          o_overflow
);

    localparam int unsigned LW = $clog2(TABLE_DEPTH + 1);

    // Sequencer state.
    logic                   r_busy;
    logic                   r_launch;
    logic [LW-1:0]          r_pos;
    logic [LW-1:0]          r_len;
    logic [VALUE_WIDTH-1:0] r_hold_key;
    logic                   r_hold_start;

    // Output register.
    logic                   r_out_valid;
    logic [LEN_W-1:0]       r_out_len;
    logic                   r_out_ovf;

    // Chain wiring.
    logic [TABLE_DEPTH:0]   w_tok;
    logic [VALUE_WIDTH-1:0] w_key [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] w_hit;
    t_cell_ctl              w_ctl;

    logic                   w_accept;
    logic                   w_walk;
    logic                   w_hit_any;
    logic                   w_fell_out;
    logic                   w_done;
    logic [LW-1:0]          n_len;
    logic [LW+LEN_W-1:0]    w_len_ext;

    assign o_ready  = ~r_busy;
    assign w_accept = i_valid & ~r_busy;

    // The chain advances only when a finished word has somewhere to go.
    assign w_ctl.en     = ~r_out_valid | i_ready;
    assign w_ctl.append = (r_pos == r_len);

    assign w_walk     = r_busy & ~r_launch & w_ctl.en;
    assign w_hit_any  = |w_hit;
    assign w_fell_out = (r_pos == LW'(TABLE_DEPTH));
    assign w_done     = w_walk & (w_hit_any | w_fell_out);
    assign n_len      = (w_hit_any && w_ctl.append) ? r_len + LW'(1) : r_len;
    assign w_len_ext  = {{LEN_W{1'b0}}, n_len};

    // Launch point of the chain.
    assign w_tok[0] = r_launch;
    assign w_key[0] = r_hold_key;

    // Row of tail cells.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        lis_cell #(
            .VALUE_WIDTH(VALUE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_tok   (w_tok[g]),
            .i_key   (w_key[g]),
            .o_tok   (w_tok[g+1]),
            .o_key   (w_key[g+1]),
            .o_hit   (w_hit[g])
        );
    end

    // Hold the accepted word until it is launched into the chain.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hold_key   <= i_sample;
            r_hold_start <= i_start_req;
        end
    end

    // Sequencer: launch, walk, finish.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_launch <= 1'b0;
            r_pos    <= '0;
            r_len    <= '0;
        end else begin
            if (w_accept) begin
                r_busy   <= 1'b1;
                r_launch <= 1'b1;
            end else if (r_launch && w_ctl.en) begin
                // A start request empties the table; the walk then appends at cell zero.
                r_launch <= 1'b0;
                r_pos    <= '0;
                if (r_hold_start) begin
                    r_len <= '0;
                end
            end else if (w_done) begin
                r_busy <= 1'b0;
                r_len  <= n_len;
            end else if (w_walk) begin
                r_pos <= r_pos + LW'(1);
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_len <= w_len_ext[LEN_W-1:0];
            r_out_ovf <= ~w_hit_any;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_lis_length = r_out_len;
    assign o_overflow   = r_out_ovf;

`ifndef SYNTHESIS
    // At most one cell reports a hit.
    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one cell hit");

    // The live length never passes the table depth.
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(TABLE_DEPTH))
        else $error("live length beyond table depth");

    // A hit only happens while a word is walking the chain.
    a_hit_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit_any |-> (r_busy && !r_launch))
        else $error("cell hit with no word in work");

    // An overflow is only reported with a full table.
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && !w_hit_any) |-> (r_len == LW'(TABLE_DEPTH)))
        else $error("overflow with a table that is not full");
`endif

endmodule

FILE: tb/sv/lis_length_tracker_top_tb.sv
// Testbench for the increasing-subsequence length tracker: directed and random words.
`timescale 1ns / 100ps

module lis_length_tracker_top_tb;
    import lis_pkg::*;

    localparam int unsigned DEPTH       = TABLE_DEPTH_DEF;
    localparam int unsigned VW          = VALUE_WIDTH_DEF;
    localparam int unsigned PHASE_WORDS = 200;
    localparam int unsigned LIMIT_CYCLES = 600000;
    localparam int unsigned MAX_REPORTS = 10;

    localparam logic signed [VW-1:0] S_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] S_MAX = {1'b0, {(VW-1){1'b1}}};

    // One input word and one result word.
    typedef struct packed {
        logic signed [VW-1:0] sample;
        logic                 start;
    } t_lis_word;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             ovf;
    } t_lis_result;

    // Kinds of random sequence.
    typedef enum int unsigned {
        SEQ_RANDOM,
        SEQ_NARROW,
        SEQ_FILL,
        SEQ_RISE_DIPS,
        SEQ_NOISE
    } t_seq_kind;

    logic                 i_clk       = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic signed [VW-1:0] in_sample   = '0;
    logic                 in_start    = 1'b0;
    logic                 out_ready   = 1'b0;
    logic                 in_taken    = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic [LEN_W-1:0]     o_lis_length;
    logic                 o_overflow;

    t_lis_word   pending_words[$];
    t_lis_result expected_lengths[$];

    int unsigned send_idle_pct   = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned words_queued    = 0;
    int unsigned words_sent      = 0;
    int unsigned lengths_checked = 0;
    int unsigned mismatches      = 0;
    int unsigned overflows_seen  = 0;
    int unsigned longest_seen    = 0;
    int unsigned cycle_cnt       = 0;

    // Predictor state: the tail table and its live length.
    logic signed [VW-1:0] tail_vals[DEPTH];
    int unsigned          live_len = 0;

    lis_length_tracker_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_ready      (o_ready),
        .i_sample     (in_sample),
        .i_start_req  (in_start),
        .o_valid      (o_valid),
        .i_ready      (out_ready),
        .o_lis_length (o_lis_length),
        .o_overflow   (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // Update the tail table with one word and return the length it leaves.
    function automatic t_lis_result track_lis(input logic signed [VW-1:0] s, input logic st);
        t_lis_result r;
        int unsigned k;
        r.ovf = 1'b0;
        if (st || live_len == 0) begin
            tail_vals[0] = s;
            live_len = 1;
        end else if (s < tail_vals[0]) begin
            tail_vals[0] = s;
        end else if (s > tail_vals[live_len-1]) begin
            if (live_len < DEPTH) begin
                tail_vals[live_len] = s;
                live_len++;
            end else begin
                r.ovf = 1'b1;
            end
        end else begin
            // The ceiling: first live entry not below the sample.
            k = 0;
            while (k < live_len - 1 && tail_vals[k] < s)
                k++;
            tail_vals[k] = s;
        end
        r.len = live_len[LEN_W-1:0];
        return r;
    endfunction

    // Sender: holds a word until it is taken, then offers the next one or idles.
    always @(negedge i_clk) begin
        t_lis_word w;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_taken) begin
            in_valid <= 1'b1;
        end else if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            w = pending_words.pop_front();
            in_valid  <= 1'b1;
            in_sample <= w.sample;
            in_start  <= w.start;
        end else begin
            in_valid <= 1'b0;
        end
    end

    // Receiver: stalls at random.
    always @(negedge i_clk) begin
        out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: checks each result, then predicts for each accepted word.
    always @(posedge i_clk) begin
        t_lis_result e;
        in_taken <= rst_n && in_valid && o_ready;
        if (rst_n) begin
            if (o_valid && out_ready) begin
                if (expected_lengths.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Unexpected result: len %0d ovf %0b", o_lis_length, o_overflow);
                end else begin
                    e = expected_lengths.pop_front();
                    if (o_lis_length !== e.len || o_overflow !== e.ovf) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"Mismatch on result %0d: expected len %0d ovf %0b, ",
                                      "got len %0d ovf %0b"},
                                     lengths_checked, e.len, e.ovf, o_lis_length, o_overflow);
                    end
                    if (o_overflow === 1'b1)
                        overflows_seen++;
                    if (o_lis_length > longest_seen)
                        longest_seen = o_lis_length;
                end
                lengths_checked++;
            end
            if (in_valid && o_ready) begin
                expected_lengths.push_back(track_lis(in_sample, in_start));
                words_sent <= words_sent + 1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic queue_word(input logic signed [VW-1:0] s, input logic st);
        t_lis_word w;
        w.sample = s;
        w.start  = st;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Mostly random values, with the extremes and small values around zero mixed in.
    function automatic logic signed [VW-1:0] draw_value();
        case ($urandom_range(0, 9))
            0: return S_MIN;
            1: return S_MAX;
            2: return $signed($urandom_range(0, 6)) - 3;
            default: return $urandom;
        endcase
    endfunction

    // A strictly rising run placed anywhere in the value range; dips land inside the table.
    task automatic queue_rising(input int unsigned count, input bit with_dips);
        longint vals[$];
        longint acc;
        longint shift;
        longint v;
        acc = 0;
        for (int unsigned i = 0; i < count; i++) begin
            acc += $urandom_range(1, 1000);
            vals.push_back(acc);
        end
        case ($urandom_range(0, 3))
            0: shift = longint'(S_MIN) - vals[0];
            1: shift = longint'(S_MAX) - acc;
            default: shift = longint'(S_MIN) - 1
                             + longint'($urandom_range(0, 32'(64'hFFFF_FFFF - acc)));
        endcase
        for (int unsigned i = 0; i < count; i++) begin
            v = vals[i] + shift;
            if (with_dips && i > 0 && $urandom_range(0, 4) == 0)
                v = vals[$urandom_range(0, i - 1)] + shift - $urandom_range(0, 1);
            queue_word(VW'(v), i == 0);
        end
    endtask

    initial begin
        int unsigned phase_base;
        int unsigned n;
        int unsigned idle_tab[4];
        int unsigned stall_tab[4];
        idle_tab  = '{0, 59, 0, 37};
        stall_tab = '{0, 0, 59, 37};

        repeat (12) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        for (int unsigned p = 0; p < 4; p++) begin
            send_idle_pct  = idle_tab[p];
            recv_stall_pct = stall_tab[p];
            phase_base = words_queued;

            if (p == 0) begin
                // No start after reset, replacing the first entry, append, equal values.
                queue_word(5, 1'b0);
                queue_word(3, 1'b0);
                queue_word(7, 1'b0);
                queue_word(7, 1'b0);
                queue_word(5, 1'b0);
                queue_word(3, 1'b0);
                queue_word(S_MAX, 1'b0);
                queue_word(S_MIN, 1'b0);
                queue_word(S_MAX, 1'b0);
                // Fresh sequences across the sign boundary and at the extremes.
                queue_word(S_MAX, 1'b1);
                queue_word(S_MIN, 1'b0);
                queue_word(-1, 1'b0);
                queue_word(0, 1'b0);
                queue_word(S_MAX - 1, 1'b0);
                queue_word(S_MAX, 1'b0);
                queue_word(S_MIN + 1, 1'b0);
                queue_word(-1, 1'b0);
                queue_word(S_MIN, 1'b1);
                queue_word(S_MIN, 1'b0);
                queue_word(0, 1'b1);
                queue_word(0, 1'b1);
                queue_word(32'sh5555_5555, 1'b0);
                queue_word(32'shAAAA_AAAA, 1'b0);
            end

            while (words_queued - phase_base < PHASE_WORDS) begin
                t_seq_kind kind;
                case ($urandom_range(0, 9))
                    0, 1, 2: kind = SEQ_RANDOM;
                    3, 4:    kind = SEQ_NARROW;
                    5:       kind = SEQ_FILL;
                    6, 7:    kind = SEQ_RISE_DIPS;
                    default: kind = SEQ_NOISE;
                endcase
                case (kind)
                    SEQ_RANDOM: begin
                        n = $urandom_range(1, 20);
                        for (int unsigned i = 0; i < n; i++)
                            queue_word(draw_value(), i == 0);
                    end
                    SEQ_NARROW: begin
                        n = $urandom_range(1, 30);
                        for (int unsigned i = 0; i < n; i++)
                            queue_word($signed($urandom_range(0, 16)) - 8, i == 0);
                    end
                    SEQ_FILL:      queue_rising($urandom_range(DEPTH + 1, DEPTH + 8), 1'b0);
                    SEQ_RISE_DIPS: queue_rising($urandom_range(20, DEPTH + 26), 1'b1);
                    default:       queue_word(draw_value(), 1'($urandom_range(0, 1)));
                endcase
            end

            // Hold the sender until every result of this phase is back.
            while (words_sent != words_queued || expected_lengths.size() != 0)
                @(negedge i_clk);
        end

        // Allow for a stray late result after the last one expected.
        repeat (DEPTH + 10) @(negedge i_clk);

        $display("Sent %0d words over four handshake phases; checked %0d lengths.",
                 words_sent, lengths_checked);
        $display("Saw %0d dropped appends; longest length %0d; %0d mismatches.",
                 overflows_seen, longest_seen, mismatches);
        if (mismatches == 0 && expected_lengths.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
